FILE: rtl/layer_insertion_sorter_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the layer insertion sorter
// ----------------------------------------------------------------------------
`ifndef LAYER_INSERTION_SORTER_DEFINES_SVH
`define LAYER_INSERTION_SORTER_DEFINES_SVH

// Property must hold at every rising clock edge outside reset.
`define LIS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define LIS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/lis_pkg.sv
// ----------------------------------------------------------------------------
// lis_pkg
// Types and constants shared by the layer insertion sorter and its interfaces.
// ----------------------------------------------------------------------------
package lis_pkg;

  localparam int unsigned MaxEntries  = 64;
  localparam int unsigned KeyWidth    = 16;
  localparam int unsigned LayerWidth  = 16;
  localparam int unsigned HandleWidth = 16;
  localparam int unsigned IdxWidth    = $clog2(MaxEntries);
  localparam int unsigned CntWidth    = $clog2(MaxEntries + 1);

  typedef struct packed {
    logic signed [LayerWidth-1:0] layer_key;
    logic [HandleWidth-1:0]       object_handle;
    logic                         list_end;
  } in_item_t;

  typedef struct packed {
    logic [HandleWidth-1:0]       sorted_handle;
    logic signed [LayerWidth-1:0] sorted_layer;
    logic                         run_last;
    logic                         overflow;
  } out_item_t;

  // One store entry: key and handle share a memory word.
  typedef struct packed {
    logic [KeyWidth-1:0]    key;
    logic [HandleWidth-1:0] handle;
  } entry_t;

endpackage

FILE: rtl/lis_in_if.sv
// ----------------------------------------------------------------------------
// lis_in_if
// Valid/ready channel carrying one object of the list per transaction.
// ----------------------------------------------------------------------------
interface lis_in_if import lis_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/lis_out_if.sv
// ----------------------------------------------------------------------------
// lis_out_if
// Valid/ready channel carrying one sorted entry per transaction.
// ----------------------------------------------------------------------------
interface lis_out_if import lis_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/layer_insertion_sorter.sv
// Insert: an object is accepted in StIdle; each stored entry that moves up
//   takes a read (StInsRd) and a shift (StInsCmp); the final write follows.
// Flow: one object at a time; the shift loop through the single-port-read
//   store sets the rate. On a list end, each entry is read, then held for the sink.
// Reset: asynchronous, clears the fill count, overflow flag and control FSM.
//   The store itself is not cleared; no clearing pass is needed.
// ----------------------------------------------------------------------------
// layer_insertion_sorter
// Stable insertion sort of a list of objects by signed layer key, emitting the
// sorted run on the transaction flagged list_end.
// ----------------------------------------------------------------------------
module layer_insertion_sorter
  import lis_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  lis_in_if.sink    in_i,
  lis_out_if.source out_o
);

  `include "layer_insertion_sorter_defines.svh"

  // One-hot control FSM.
  typedef enum logic [4:0] {
    StIdle    = 5'b00001,
    StInsRd   = 5'b00010,  // issue read of the entry below the hole, or fill place 0
    StInsCmp  = 5'b00100,  // compare, then shift up or drop new entry in
    StEmitRd  = 5'b01000,  // issue read of the next entry to emit
    StEmitOut = 5'b10000   // present entry, wait for the sink
  } state_e;

  state_e state_q, state_d;

  // Item being inserted.
  logic [KeyWidth-1:0]    key_q;
  logic [HandleWidth-1:0] handle_q;
  logic                   last_q;

  // pos_q marks the hole the new entry is moving down into.
  logic [IdxWidth-1:0] pos_q, pos_d;
  logic [IdxWidth-1:0] idx_q, idx_d;
  logic [CntWidth-1:0] count_q, count_d;
  logic                ovf_q, ovf_d;

  // Store: synchronous write, registered read.
  entry_t              mem_q [MaxEntries];
  entry_t              rd_data_q;
  logic                wr_en, rd_en;
  logic [IdxWidth-1:0] wr_addr, rd_addr;
  entry_t              wr_data;

  logic in_fire, out_fire, emit_last, store_full, key_gt;

  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_o.valid && out_o.ready;
  assign store_full = (count_q == CntWidth'(MaxEntries));
  assign emit_last  = ((CntWidth'(idx_q) + CntWidth'(1)) == count_q);
  // Strict greater-than keeps equal layers in arrival order.
  assign key_gt     = ($signed(rd_data_q.key) > $signed(key_q));

  assign in_i.ready = (state_q == StIdle);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      key_q    <= in_i.data.layer_key[KeyWidth-1:0];
      handle_q <= in_i.data.object_handle;
      last_q   <= in_i.data.list_end;
    end
  end

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    idx_d   = idx_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    wr_en   = 1'b0;
    wr_addr = pos_q;
    wr_data = '{key: key_q, handle: handle_q};
    rd_en   = 1'b0;
    rd_addr = pos_q - IdxWidth'(1);

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (store_full) begin
            // Dropped; a list end still flushes the full store.
            ovf_d = 1'b1;
            if (in_i.data.list_end) begin
              idx_d   = '0;
              state_d = StEmitRd;
            end
          end else begin
            pos_d   = count_q[IdxWidth-1:0];
            state_d = StInsRd;
          end
        end
      end

      StInsRd: begin
        if (pos_q == '0) begin
          // Reached the bottom: new entry goes in place 0.
          wr_en   = 1'b1;
          count_d = count_q + CntWidth'(1);
          idx_d   = '0;
          state_d = last_q ? StEmitRd : StIdle;
        end else begin
          rd_en   = 1'b1;
          state_d = StInsCmp;
        end
      end

      StInsCmp: begin
        wr_en = 1'b1;
        if (key_gt) begin
          wr_data = rd_data_q;
          pos_d   = pos_q - IdxWidth'(1);
          state_d = StInsRd;
        end else begin
          count_d = count_q + CntWidth'(1);
          idx_d   = '0;
          state_d = last_q ? StEmitRd : StIdle;
        end
      end

      StEmitRd: begin
        rd_en   = 1'b1;
        rd_addr = idx_q;
        state_d = StEmitOut;
      end

      StEmitOut: begin
        if (out_fire) begin
          if (emit_last) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = StIdle;
          end else begin
            idx_d   = idx_q + IdxWidth'(1);
            state_d = StEmitRd;
          end
        end
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pos_q   <= '0;
      idx_q   <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      idx_q   <= idx_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  // Read data register holds the entry while the sink stalls.
  assign out_o.valid              = (state_q == StEmitOut);
  assign out_o.data.sorted_handle = rd_data_q.handle;
  assign out_o.data.sorted_layer  = LayerWidth'($signed(rd_data_q.key));
  assign out_o.data.run_last      = emit_last;
  assign out_o.data.overflow      = ovf_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `LIS_ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > CntWidth'(MaxEntries), "fill count beyond store depth")
  `LIS_ASSERT_NEVER(a_no_overlap, clk_i, rst_ni, in_i.ready && out_o.valid, "input taken while emitting")
  `LIS_ASSERT(a_full_sets_ovf, clk_i, rst_ni, in_fire && store_full |=> ovf_q, "drop on full store not flagged")
  `LIS_ASSERT(a_run_clears, clk_i, rst_ni, out_fire && out_o.data.run_last |=> (count_q == '0) && !ovf_q, "store not emptied after run")

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// Testbench for layer_insertion_sorter
// Sends lists of objects (signed layer, handle, list end) through the input
// channel, keeps its own sorted copy of each list, and checks every sorted
// entry coming out against it. It covers extreme keys, ties, single-object
// lists, full-store overflow and random lists under sender and receiver
// back-pressure.
// ----------------------------------------------------------------------------
module tb;
  import lis_pkg::*;

  // Limits for the watchdog and the drain at the end of the run. The quiet
  // limit lies well above the longest insert, a shift through the whole store,
  // so reaching it means the block is stuck.
  localparam int unsigned QuietLimit  = 4000;
  localparam int unsigned DrainCycles = 200;
  localparam int unsigned ReportLimit = 10;

  logic clk_i;
  logic rst_ni;

  lis_in_if  in_ch ();
  lis_out_if out_ch ();

  layer_insertion_sorter DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // Idle and stall rates in percent, changed between test phases.
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;

  int unsigned error_count;
  int unsigned quiet_cycles;

  // Our own copy of the sorted store: keys and handles in ascending layer
  // order, the fill level, and whether this list lost an object.
  logic signed [LayerWidth-1:0] list_key    [MaxEntries];
  logic [HandleWidth-1:0]       list_handle [MaxEntries];
  int unsigned                  list_fill;
  bit                           list_dropped;

  // Sorted entries still owed by the block, oldest first.
  out_item_t sorted_run_q[$];

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Failure bookkeeping: the first few are printed, the rest only counted.
  // --------------------------------------------------------------------------
  task automatic note_failure(input string what);
    error_count++;
    if (error_count <= ReportLimit) begin
      $display("ERROR at %0t: %s", $time, what);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sort step: insert one accepted object into the local store and, on list
  // end, queue the whole run in order. Strict greater-than keeps equal layers
  // in arrival order. A full store drops the object, the list end included.
  // --------------------------------------------------------------------------
  function automatic void insert_object(input in_item_t obj);
    logic signed [LayerWidth-1:0] key;
    int unsigned pos;
    out_item_t entry;
    key = obj.layer_key;
    if (list_fill >= MaxEntries) begin
      list_dropped = 1'b1;
    end else begin
      pos = list_fill;
      while (pos > 0 && list_key[pos-1] > key) begin
        list_key[pos]    = list_key[pos-1];
        list_handle[pos] = list_handle[pos-1];
        pos--;
      end
      list_key[pos]    = key;
      list_handle[pos] = obj.object_handle;
      list_fill++;
    end
    if (obj.list_end) begin
      for (int unsigned i = 0; i < list_fill; i++) begin
        entry.sorted_handle = list_handle[i];
        entry.sorted_layer  = list_key[i];
        entry.run_last      = (i + 1 == list_fill);
        entry.overflow      = list_dropped;
        sorted_run_q.push_back(entry);
      end
      list_fill    = 0;
      list_dropped = 1'b0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Send one object. Inputs change on the falling edge; the transaction is
  // taken on the rising edge where valid and ready are both high. Valid is
  // held until taken, and stays high between objects unless the sender idles.
  // --------------------------------------------------------------------------
  task automatic send_object(input logic signed [LayerWidth-1:0] key,
                             input logic [HandleWidth-1:0] handle,
                             input logic last);
    in_item_t obj;
    obj.layer_key     = key;
    obj.object_handle = handle;
    obj.list_end      = last;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= in_item_t'($urandom);
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= obj;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    insert_object(obj);
  endtask

  // Random layer: either a narrow band around zero (lots of ties) or the
  // full signed range.
  function automatic logic signed [LayerWidth-1:0] pick_layer(input bit narrow);
    if (narrow) begin
      return LayerWidth'(int'($urandom_range(8)) - 4);
    end
    return LayerWidth'($urandom);
  endfunction

  // --------------------------------------------------------------------------
  // Directed lists: extremes, single-object lists, ties, worst-case shifting.
  // --------------------------------------------------------------------------
  task automatic test_directed_lists();
    // Single-object lists at both ends of the key and handle ranges.
    send_object(16'sh8000, 16'h0000, 1'b1);
    send_object(16'sh7fff, 16'hffff, 1'b1);

    // Ties on layer 5 must come out in arrival order, between the extremes.
    send_object(16'sd5,    16'h0001, 1'b0);
    send_object(-16'sd3,   16'h0002, 1'b0);
    send_object(16'sd5,    16'h0003, 1'b0);
    send_object(16'sh7fff, 16'h0004, 1'b0);
    send_object(16'sh8000, 16'h0005, 1'b0);
    send_object(16'sd5,    16'h0006, 1'b0);
    send_object(16'sd0,    16'h0007, 1'b1);

    // Descending keys: every insert shifts the whole store.
    for (int k = 10; k >= 3; k--) begin
      send_object(LayerWidth'(k), HandleWidth'(16'h5a00 + k), k == 3);
    end

    // Ascending keys: no shifting at all.
    for (int k = 0; k < 4; k++) begin
      send_object(LayerWidth'(-100 + k * 50), HandleWidth'(16'ha500 + k), k == 3);
    end
  endtask

  // --------------------------------------------------------------------------
  // Overflow: fill the store, then drop objects. The first list loses only
  // its list end; the second loses a plain object and the list end. The list
  // that follows must come out with the overflow flag clear again.
  // --------------------------------------------------------------------------
  task automatic test_store_overflow();
    for (int unsigned k = 0; k < MaxEntries; k++) begin
      send_object(pick_layer(k[0]), HandleWidth'($urandom), 1'b0);
    end
    // Would sort first if it were kept.
    send_object(16'sh8000, 16'hffff, 1'b1);

    for (int unsigned k = 0; k < MaxEntries; k++) begin
      send_object(pick_layer(k[1]), HandleWidth'($urandom), 1'b0);
    end
    send_object(16'sh8000, 16'h0000, 1'b0);
    send_object(16'sh7fff, 16'hffff, 1'b1);

    send_object(16'sd1, 16'h1234, 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Random lists: mostly short, now and then longer; keys either clustered
  // for ties or spread over the full range.
  // --------------------------------------------------------------------------
  task automatic test_random_lists(input int unsigned n_objects);
    int unsigned sent;
    int unsigned len;
    bit narrow;
    sent = 0;
    while (sent < n_objects) begin
      len    = ($urandom_range(7) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      narrow = $urandom_range(1);
      for (int unsigned k = 1; k <= len; k++) begin
        send_object(pick_layer(narrow), HandleWidth'($urandom), k == len);
      end
      sent += len;
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: ready changes on the falling edge, stalling at the phase rate.
  // --------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Result check and watchdog, both on the rising edge. Each accepted entry
  // is compared field by field with the oldest owed entry. The watchdog
  // counts cycles in which neither channel moves a transaction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_item_t want;
    out_item_t got;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (sorted_run_q.size() == 0) begin
          note_failure($sformatf("unexpected entry handle %0d layer %0d last %0b ovf %0b",
                                 got.sorted_handle, got.sorted_layer, got.run_last,
                                 got.overflow));
        end else begin
          want = sorted_run_q.pop_front();
          if (got.sorted_handle !== want.sorted_handle) begin
            note_failure($sformatf("sorted_handle expected %0d got %0d",
                                   want.sorted_handle, got.sorted_handle));
          end
          if (got.sorted_layer !== want.sorted_layer) begin
            note_failure($sformatf("sorted_layer expected %0d got %0d",
                                   want.sorted_layer, got.sorted_layer));
          end
          if (got.run_last !== want.run_last) begin
            note_failure($sformatf("run_last expected %0b got %0b",
                                   want.run_last, got.run_last));
          end
          if (got.overflow !== want.overflow) begin
            note_failure($sformatf("overflow expected %0b got %0b",
                                   want.overflow, got.overflow));
          end
        end
      end

      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("Watchdog: no transaction for %0d cycles, %0d entries owed",
                 quiet_cycles, sorted_run_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset once, then phases with different idling patterns,
  // each running some of the tests, then drain and report.
  // --------------------------------------------------------------------------
  initial begin
    error_count   = 0;
    quiet_cycles  = 0;
    list_fill     = 0;
    list_dropped  = 1'b0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    rst_ni        = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // No idling on either side.
    test_directed_lists();
    test_random_lists(8);

    // Sender idle most of the time.
    src_idle_pct  = 64;
    snk_stall_pct = 0;
    test_random_lists(8);

    // Receiver stalling most of the time; long overflow runs back up here.
    src_idle_pct  = 0;
    snk_stall_pct = 64;
    test_store_overflow();
    test_random_lists(8);

    // Both sides idling now and then.
    src_idle_pct  = 25;
    snk_stall_pct = 25;
    test_random_lists(8);

    @(negedge clk_i);
    in_ch.valid <= 1'b0;

    // Wait for every owed entry, then give the block time to show anything
    // extra it might still send.
    while (sorted_run_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/lis_pkg.sv
rtl/lis_in_if.sv
rtl/lis_out_if.sv
rtl/layer_insertion_sorter.sv
test/tb.sv
